// ===== sv/mrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfc_pkg
// shared types, codes and the crc-16/modbus byte step for the reply checker
// ----------------------------------------------------------------------------
package mrfc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_count;
    typedef logic [15:0] t_crc;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_err;
    typedef logic [1:0] t_cfg_idx;

    // request kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    // verdict codes
    localparam t_err ERR_OK   = 2'd0;
    localparam t_err ERR_LEN  = 2'd1;
    localparam t_err ERR_ADDR = 2'd2;
    localparam t_err ERR_CRC  = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx CFG_LEN_KIND0 = 2'd0;
    localparam t_cfg_idx CFG_LEN_KIND1 = 2'd1;
    localparam t_cfg_idx CFG_LEN_KIND2 = 2'd2;
    localparam t_cfg_idx CFG_LEN_KIND3 = 2'd3;

    localparam int    NUM_KINDS = 4;
    localparam t_byte LEN_KIND0_RST = 8'd43;
    localparam t_byte LEN_KIND1_RST = 8'd19;
    localparam t_byte LEN_KIND2_RST = 8'd10;
    localparam t_byte LEN_KIND3_RST = 8'd49;

    localparam t_count COUNT_MAX  = 9'd511;
    localparam t_crc   CRC_INIT   = 16'hFFFF;
    localparam t_crc   CRC_POLY   = 16'hA001;
    localparam logic [1:0] CRC_BYTES_FULL = 2'd2;

    // one byte through the reflected crc, bit by bit
    function automatic t_crc crc16_byte(input t_crc crc_in, input t_byte b);
        t_crc c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/mrfc_in_if.sv =====
// ----------------------------------------------------------------------------
// mrfc_in_if
// request channel of the reply checker: start requests and frame bytes
// ----------------------------------------------------------------------------
interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;
    logic       last_byte;
    logic [1:0] sensor_kind;
    logic [7:0] slave_address;

    modport source (
        output valid, mode, byte_value, last_byte, sensor_kind, slave_address,
        input  ready
    );
    modport sink (
        input  valid, mode, byte_value, last_byte, sensor_kind, slave_address,
        output ready
    );
endinterface

// ===== sv/mrfc_out_if.sv =====
// ----------------------------------------------------------------------------
// mrfc_out_if
// verdict channel of the reply checker
// ----------------------------------------------------------------------------
interface mrfc_out_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [1:0] error_code;
    logic [8:0] frame_length;

    modport source (
        output valid, frame_ok, error_code, frame_length,
        input  ready
    );
    modport sink (
        input  valid, frame_ok, error_code, frame_length,
        output ready
    );
endinterface

// ===== sv/mrfc_byte_step.sv =====
// ----------------------------------------------------------------------------
// mrfc_byte_step
// per-byte frame update: position decode, crc step and received crc capture
// ----------------------------------------------------------------------------
module mrfc_byte_step (
    input  mrfc_pkg::t_count i_idx,
    input  mrfc_pkg::t_byte  i_byte,
    input  mrfc_pkg::t_byte  i_held_address,
    input  mrfc_pkg::t_crc   i_crc,
    input  mrfc_pkg::t_byte  i_plen,
    input  mrfc_pkg::t_crc   i_rcv_crc,
    input  logic [1:0]       i_crc_seen,
    input  logic             i_addr_match,
    output mrfc_pkg::t_crc   o_crc,
    output mrfc_pkg::t_byte  o_plen,
    output mrfc_pkg::t_crc   o_rcv_crc,
    output logic [1:0]       o_crc_seen,
    output logic             o_addr_match
);
    import mrfc_pkg::*;

    t_count crc_pos;
    logic   seen_inc;

    assign o_addr_match = (i_idx == 9'd0) ? (i_byte == i_held_address) : i_addr_match;
    assign o_plen       = (i_idx == 9'd2) ? i_byte : i_plen;
    assign crc_pos      = {1'b0, o_plen} + 9'd3;
    assign seen_inc     = (i_crc_seen < CRC_BYTES_FULL);

    always_comb begin
        o_crc      = i_crc;
        o_rcv_crc  = i_rcv_crc;
        o_crc_seen = i_crc_seen;
        if (i_idx < 9'd3 || i_idx < crc_pos) begin
            o_crc = crc16_byte(i_crc, i_byte);
        end else if (i_idx == crc_pos) begin
            o_rcv_crc = {i_rcv_crc[15:8], i_byte};
            if (seen_inc) begin
                o_crc_seen = i_crc_seen + 2'd1;
            end
        end else if (i_idx == crc_pos + 9'd1) begin
            o_rcv_crc = {i_byte, i_rcv_crc[7:0]};
            if (seen_inc) begin
                o_crc_seen = i_crc_seen + 2'd1;
            end
        end
    end

endmodule

// ===== sv/modbus_reply_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_reply_frame_checker_unit
// the verdict is registered and is on the output in the cycle after the last byte is taken
// throughput: one request per cycle, limited only by the single output register
// the frame state update and crc step are combinational, ahead of the verdict register
// reset: synchronous active low; length registers return to 43/19/10/49, the
// crc to 0xffff, the held address and kind to zero and the output empties
// ----------------------------------------------------------------------------
module modbus_reply_frame_checker_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  mrfc_pkg::t_cfg_idx i_cfg_index,
    input  mrfc_pkg::t_byte   i_cfg_data,
    // request and verdict channels
    mrfc_in_if.sink           i_in,
    mrfc_out_if.source        o_out
);
    import mrfc_pkg::*;

    // expected reply lengths, one per sensor kind
    t_byte r_exp_len [NUM_KINDS];

    // frame state
    t_crc   r_crc,        n_crc;
    t_count r_count,      n_count;
    t_byte  r_plen,       n_plen;
    t_crc   r_rcv_crc,    n_rcv_crc;
    logic [1:0] r_crc_seen, n_crc_seen;
    logic   r_addr_match, n_addr_match;
    t_byte  r_held_addr,  n_held_addr;
    t_kind  r_held_kind,  n_held_kind;

    // verdict register
    logic   r_out_valid,  n_out_valid;
    logic   r_frame_ok,   n_frame_ok;
    t_err   r_err,        n_err;
    t_count r_len,        n_len;

    // byte step results
    t_crc   s_crc;
    t_byte  s_plen;
    t_crc   s_rcv_crc;
    logic [1:0] s_crc_seen;
    logic   s_addr_match;

    logic   in_fire;
    t_count cnt_next;
    t_err   verdict;

    // take a request whenever the verdict register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // byte position saturates at the top of the counter
    assign cnt_next = (r_count != COUNT_MAX) ? r_count + 9'd1 : r_count;

    mrfc_byte_step u_step (
        .i_idx          (r_count),
        .i_byte         (i_in.byte_value),
        .i_held_address (r_held_addr),
        .i_crc          (r_crc),
        .i_plen         (r_plen),
        .i_rcv_crc      (r_rcv_crc),
        .i_crc_seen     (r_crc_seen),
        .i_addr_match   (r_addr_match),
        .o_crc          (s_crc),
        .o_plen         (s_plen),
        .o_rcv_crc      (s_rcv_crc),
        .o_crc_seen     (s_crc_seen),
        .o_addr_match   (s_addr_match)
    );

    // checks in priority order: length, address, then crc (short frame counts as crc)
    always_comb begin
        if (cnt_next != {1'b0, r_exp_len[r_held_kind]}) begin
            verdict = ERR_LEN;
        end else if (!s_addr_match) begin
            verdict = ERR_ADDR;
        end else if (s_crc_seen != CRC_BYTES_FULL || s_rcv_crc != s_crc) begin
            verdict = ERR_CRC;
        end else begin
            verdict = ERR_OK;
        end
    end

    // next frame state
    always_comb begin
        n_crc        = r_crc;
        n_count      = r_count;
        n_plen       = r_plen;
        n_rcv_crc    = r_rcv_crc;
        n_crc_seen   = r_crc_seen;
        n_addr_match = r_addr_match;
        n_held_addr  = r_held_addr;
        n_held_kind  = r_held_kind;
        n_frame_ok   = r_frame_ok;
        n_err        = r_err;
        n_len        = r_len;
        n_out_valid  = r_out_valid && !o_out.ready;

        if (in_fire) begin
            if (i_in.mode == MODE_START || i_in.last_byte) begin
                // fresh frame after a start request or a verdict
                n_crc        = CRC_INIT;
                n_count      = '0;
                n_plen       = '0;
                n_rcv_crc    = '0;
                n_crc_seen   = '0;
                n_addr_match = 1'b0;
            end else begin
                n_crc        = s_crc;
                n_count      = cnt_next;
                n_plen       = s_plen;
                n_rcv_crc    = s_rcv_crc;
                n_crc_seen   = s_crc_seen;
                n_addr_match = s_addr_match;
            end

            if (i_in.mode == MODE_START) begin
                n_held_addr = i_in.slave_address;
                n_held_kind = i_in.sensor_kind;
            end else if (i_in.last_byte) begin
                n_out_valid = 1'b1;
                n_frame_ok  = (verdict == ERR_OK);
                n_err       = verdict;
                n_len       = cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len[CFG_LEN_KIND0] <= LEN_KIND0_RST;
            r_exp_len[CFG_LEN_KIND1] <= LEN_KIND1_RST;
            r_exp_len[CFG_LEN_KIND2] <= LEN_KIND2_RST;
            r_exp_len[CFG_LEN_KIND3] <= LEN_KIND3_RST;
        end else if (i_cfg_we) begin
            r_exp_len[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_count      <= '0;
            r_plen       <= '0;
            r_rcv_crc    <= '0;
            r_crc_seen   <= '0;
            r_addr_match <= 1'b0;
            r_held_addr  <= '0;
            r_held_kind  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_crc        <= n_crc;
            r_count      <= n_count;
            r_plen       <= n_plen;
            r_rcv_crc    <= n_rcv_crc;
            r_crc_seen   <= n_crc_seen;
            r_addr_match <= n_addr_match;
            r_held_addr  <= n_held_addr;
            r_held_kind  <= n_held_kind;
            r_out_valid  <= n_out_valid;
        end
    end

    // verdict payload needs no reset
    always_ff @(posedge i_clk) begin
        r_frame_ok <= n_frame_ok;
        r_err      <= n_err;
        r_len      <= n_len;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_ok     = r_frame_ok;
    assign o_out.error_code   = r_err;
    assign o_out.frame_length = r_len;

endmodule

// ===== tb/tb_modbus_reply_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_modbus_reply_frame_checker_unit
// self-checking bench for the modbus reply checker: a short table of hand-made
// requests with their verdicts written in, a saturating long frame, then
// randomised reply frames under four idling patterns and four sets of length
// registers, scored against an in-bench model of the crc, length and address checks
// ----------------------------------------------------------------------------
module tb_modbus_reply_frame_checker_unit;

    import mrfc_pkg::*;

    // expected verdict as the output channel carries it
    typedef struct packed {
        logic   ok;
        t_err   code;
        t_count length;
    } t_verdict;

    // one row of the hand-made request table
    typedef struct packed {
        logic     mode;
        t_byte    data;
        logic     last;
        t_kind    kind;
        t_byte    addr;
        logic     typed;     // verdict written into the row itself
        t_verdict verdict;
    } t_row;

    localparam int STALL_LIMIT  = 4000;  // cycles with no request or verdict moving
    localparam int GAP_CAP      = 40;    // longest sender pause in cycles
    localparam int SETTLE       = 4;     // quiet cycles before a register write
    localparam int PHASE_ITEMS  = 45;
    localparam int PHASE_FRAMES = 3;
    localparam int SAT_BYTES    = 515;   // runs the byte counter into its ceiling
    localparam int PRINT_CAP    = 40;

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_we;
    t_cfg_idx cfg_index;
    t_byte cfg_data;

    mrfc_in_if  req_if ();
    mrfc_out_if vrd_if ();

    modbus_reply_frame_checker_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (req_if),
        .o_out       (vrd_if)
    );

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    int src_idle_pct;            // chance per cycle that the sender holds off
    int sink_stall_pct;          // chance per cycle that the receiver stalls
    int n_fail;
    int n_req;                   // requests accepted
    int n_due;                   // verdicts predicted
    int n_code [NUM_KINDS];      // verdicts seen, per error code

    t_verdict verdict_q [$];     // verdicts still owed by the block

    // model of the checker: length registers, held poll and frame state
    t_byte  len_table [NUM_KINDS];
    t_crc   frame_crc;
    t_count byte_idx;
    t_byte  param_len;
    t_crc   rx_crc;
    logic [1:0] rx_crc_cnt;
    logic   addr_hit;
    t_byte  poll_addr;
    t_kind  poll_kind;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // crc-16/modbus, one byte, lsb first
    // ------------------------------------------------------------------
    function automatic t_crc crc_step(input t_crc acc, input t_byte b);
        t_crc c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // frame state back to idle; held poll is kept
    function automatic void clear_frame();
        frame_crc  = CRC_INIT;
        byte_idx   = '0;
        param_len  = '0;
        rx_crc     = '0;
        rx_crc_cnt = '0;
        addr_hit   = 1'b0;
    endfunction

    // advance the model by one accepted request, hand back any verdict
    function automatic void absorb_request(input logic m, input t_byte b, input logic lst,
                                           input t_kind k, input t_byte a,
                                           output logic has_v, output t_verdict v);
        t_count idx;
        logic [9:0] crc_pos;
        t_err code;
        has_v = 1'b0;
        v     = '0;
        if (m == MODE_START) begin
            poll_kind = k;
            poll_addr = a;
            clear_frame();
            return;
        end
        idx = byte_idx;
        if (byte_idx != COUNT_MAX) byte_idx++;
        if (idx == 9'd0) addr_hit = (b == poll_addr);
        if (idx == 9'd2) param_len = b;
        // crc bytes sit straight after the parameter block
        crc_pos = {2'b00, param_len} + 10'd3;
        if (idx < 9'd3 || {1'b0, idx} < crc_pos) begin
            frame_crc = crc_step(frame_crc, b);
        end else if ({1'b0, idx} == crc_pos) begin
            rx_crc[7:0] = b;
            if (rx_crc_cnt != CRC_BYTES_FULL) rx_crc_cnt++;
        end else if ({1'b0, idx} == crc_pos + 10'd1) begin
            rx_crc[15:8] = b;
            if (rx_crc_cnt != CRC_BYTES_FULL) rx_crc_cnt++;
        end
        if (!lst) return;
        // length first, then address, then crc (missing crc bytes count as bad)
        if (byte_idx != {1'b0, len_table[poll_kind]}) begin
            code = ERR_LEN;
        end else if (!addr_hit) begin
            code = ERR_ADDR;
        end else if (rx_crc_cnt != CRC_BYTES_FULL || rx_crc != frame_crc) begin
            code = ERR_CRC;
        end else begin
            code = ERR_OK;
        end
        has_v    = 1'b1;
        v.ok     = (code == ERR_OK);
        v.code   = code;
        v.length = byte_idx;
        clear_frame();
    endfunction

    // ------------------------------------------------------------------
    // table rows
    // ------------------------------------------------------------------
    function automatic t_row start_row(input t_kind k, input t_byte a,
                                       input t_byte b, input logic lst);
        t_row r;
        r = '0;
        r.mode = MODE_START;
        r.kind = k;
        r.addr = a;
        r.data = b;
        r.last = lst;
        return r;
    endfunction

    function automatic t_row byte_row(input t_byte b);
        t_row r;
        r = '0;
        r.mode = MODE_BYTE;
        r.data = b;
        return r;
    endfunction

    // closing byte with its verdict written in
    function automatic t_row last_row(input t_byte b, input t_err code, input t_count len);
        t_row r;
        r = byte_row(b);
        r.last           = 1'b1;
        r.typed          = 1'b1;
        r.verdict.ok     = (code == ERR_OK);
        r.verdict.code   = code;
        r.verdict.length = len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        n_fail++;
        if (n_fail <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // request driver: optional pause, present on the falling edge, hold until
    // taken, then let the model see it
    // ------------------------------------------------------------------
    task automatic send_req(input logic m, input t_byte b, input logic lst,
                            input t_kind k, input t_byte a,
                            input logic typed, input t_verdict tv);
        int gap;
        logic has_v;
        t_verdict v;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid         = 1'b1;
        req_if.mode          = m;
        req_if.byte_value    = b;
        req_if.last_byte     = lst;
        req_if.sensor_kind   = k;
        req_if.slave_address = a;
        do @(posedge i_clk); while (!req_if.ready);
        absorb_request(m, b, lst, k, a, has_v, v);
        n_req++;
        if (typed) begin
            verdict_q.push_back(tv);
        end else if (has_v) begin
            verdict_q.push_back(v);
        end
        if (typed || has_v) n_due++;
    endtask

    // shorthand for a request scored by the model alone
    task automatic send_plain(input logic m, input t_byte b, input logic lst,
                              input t_kind k, input t_byte a);
        send_req(m, b, lst, k, a, 1'b0, '0);
    endtask

    task automatic src_rest();
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    // every owed verdict in, then a settling wait for a byte still in flight
    task automatic wait_drained();
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input t_byte val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge i_clk);
        len_table[idx] = val;
    endtask

    task automatic set_lengths(input t_byte l0, input t_byte l1,
                               input t_byte l2, input t_byte l3);
        cfg_write(CFG_LEN_KIND0, l0);
        cfg_write(CFG_LEN_KIND1, l1);
        cfg_write(CFG_LEN_KIND2, l2);
        cfg_write(CFG_LEN_KIND3, l3);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // one random reply: mostly well formed, else bad address, bad crc, crc
    // bytes cut off, wrong length, or trailing bytes after the crc
    // ------------------------------------------------------------------
    task automatic send_frame();
        t_kind k;
        t_byte a;
        t_byte fb [$];
        t_crc  c;
        int target, len, p, trail, style, i;
        // a reply usually follows a fresh poll, sometimes reuses the held one
        if ($urandom_range(5) != 0) begin
            k = t_kind'($urandom_range(3));
            a = t_byte'($urandom_range(255));
            send_plain(MODE_START, t_byte'($urandom_range(255)), 1'($urandom_range(1)), k, a);
        end else begin
            k = poll_kind;
            a = poll_addr;
        end
        target = len_table[k];
        style  = $urandom_range(99);
        // long settings get a full-size frame only now and then
        if (target >= 5 && (target <= 60 || $urandom_range(11) == 0)) len = target;
        else len = $urandom_range(5, 24);
        if (style >= 85) len = (style >= 93) ? len + 1 : len - 1;
        trail = ($urandom_range(7) == 0) ? $urandom_range(3) : 0;
        if (trail > len - 5) trail = (len > 5) ? len - 5 : 0;
        p = len - 5 - trail;
        if (style >= 75 && style < 85) p = len - 5 + $urandom_range(1, 2);  // crc cut off
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        for (i = 0; i < len; i++) fb.push_back(t_byte'($urandom_range(255)));
        fb[0] = (style >= 65 && style < 75) ? a ^ t_byte'($urandom_range(1, 255)) : a;
        fb[2] = t_byte'(p);
        c = CRC_INIT;
        for (i = 0; i <= p + 2 && i < len; i++) c = crc_step(c, fb[i]);
        if (p + 3 < len) fb[p + 3] = c[7:0];
        if (p + 4 < len) fb[p + 4] = c[15:8];
        // corrupt one bit inside the crc coverage or the crc itself
        if (style >= 55 && style < 65 && p + 4 < len)
            fb[$urandom_range(3, p + 4)] ^= t_byte'(1 << $urandom_range(7));
        for (i = 0; i < len; i++)
            send_plain(MODE_BYTE, fb[i], (i == len - 1),
                       t_kind'($urandom_range(3)), t_byte'($urandom_range(255)));
        // loose bytes between replies
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(1, 4))
                send_plain(MODE_BYTE, t_byte'($urandom_range(255)), ($urandom_range(3) == 0),
                           t_kind'($urandom_range(3)), t_byte'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: ready redrawn every falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        vrd_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // verdict checker: oldest expectation against each accepted verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && vrd_if.valid && vrd_if.ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected verdict: code %0d length %0d",
                                          vrd_if.error_code, vrd_if.frame_length));
            end else begin
                want = verdict_q.pop_front();
                n_code[want.code]++;
                if (vrd_if.frame_ok !== want.ok)
                    report_mismatch($sformatf("frame_ok %b, wanted %b",
                                              vrd_if.frame_ok, want.ok));
                if (vrd_if.error_code !== want.code)
                    report_mismatch($sformatf("error_code %0d, wanted %0d",
                                              vrd_if.error_code, want.code));
                if (vrd_if.frame_length !== want.length)
                    report_mismatch($sformatf("frame_length %0d, wanted %0d",
                                              vrd_if.frame_length, want.length));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with nothing moving on either channel
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (vrd_if.valid && vrd_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no request or verdict moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row steer [$];
        int ph, mark_req, mark_due, i;
        logic paused;

        // every input known from time zero
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_LEN_KIND0;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_START;
        req_if.byte_value    = '0;
        req_if.last_byte     = 1'b0;
        req_if.sensor_kind   = '0;
        req_if.slave_address = '0;
        vrd_if.ready         = 1'b1;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        n_fail = 0;
        n_req  = 0;
        n_due  = 0;
        for (i = 0; i < NUM_KINDS; i++) n_code[i] = 0;

        // model at its reset values
        len_table[CFG_LEN_KIND0] = LEN_KIND0_RST;
        len_table[CFG_LEN_KIND1] = LEN_KIND1_RST;
        len_table[CFG_LEN_KIND2] = LEN_KIND2_RST;
        len_table[CFG_LEN_KIND3] = LEN_KIND3_RST;
        poll_addr = '0;
        poll_kind = '0;
        clear_frame();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // hand-made table, reset lengths 43/19/10/49
        // a byte before any poll: checked against address 0, kind 0
        steer.push_back(last_row(8'h00, ERR_LEN, 9'd1));
        // poll with last set: last and byte are ignored on a start
        steer.push_back(start_row(2'd2, 8'hFF, 8'hAA, 1'b1));
        // ten bytes, kind 2 length fits, but byte 0 is not the polled address
        steer.push_back(byte_row(8'h00));
        steer.push_back(byte_row(8'h03));
        steer.push_back(byte_row(8'h05));
        steer.push_back(byte_row(8'hFF));
        steer.push_back(byte_row(8'h00));
        steer.push_back(byte_row(8'h80));
        steer.push_back(byte_row(8'h7F));
        steer.push_back(byte_row(8'h01));
        steer.push_back(byte_row(8'h12));
        steer.push_back(last_row(8'h34, ERR_ADDR, 9'd10));
        // parameter length 255: the frame ends long before its crc bytes
        steer.push_back(start_row(2'd2, 8'h00, 8'h55, 1'b0));
        steer.push_back(byte_row(8'h00));
        steer.push_back(byte_row(8'h04));
        steer.push_back(byte_row(8'hFF));
        for (i = 0; i < 6; i++) steer.push_back(byte_row(8'hFF ^ 8'(i)));
        steer.push_back(last_row(8'hFF, ERR_CRC, 9'd10));
        // highest kind, one byte only
        steer.push_back(start_row(2'd3, 8'h80, 8'h00, 1'b0));
        steer.push_back(last_row(8'h80, ERR_LEN, 9'd1));

        foreach (steer[j])
            send_req(steer[j].mode, steer[j].data, steer[j].last, steer[j].kind,
                     steer[j].addr, steer[j].typed, steer[j].verdict);

        // one frame long enough to pin the byte counter at its ceiling
        send_plain(MODE_START, 8'h00, 1'b0, 2'd0, t_byte'($urandom_range(255)));
        for (i = 0; i < SAT_BYTES; i++)
            send_plain(MODE_BYTE, t_byte'($urandom_range(255)), (i == SAT_BYTES - 1),
                       t_kind'($urandom_range(3)), t_byte'($urandom_range(255)));

        // random replies, one idling pattern and one length set per phase
        for (ph = 0; ph < 4; ph++) begin
            src_rest();
            wait_drained();
            case (ph)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    set_lengths(8'd43, 8'd19, 8'd10, 8'd49);
                end
                1: begin
                    src_idle_pct = 78; sink_stall_pct = 0;
                    set_lengths(8'd5, 8'd12, 8'd0, 8'd20);
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 78;
                    set_lengths(8'd255, 8'd8, 8'd16, 8'd6);
                end
                default: begin
                    src_idle_pct = 17; sink_stall_pct = 17;
                    set_lengths(8'd9, 8'd255, 8'd7, 8'd14);
                end
            endcase
            mark_req = n_req;
            mark_due = n_due;
            paused   = 1'b0;
            while (n_req - mark_req < PHASE_ITEMS || n_due - mark_due < PHASE_FRAMES) begin
                send_frame();
                // once, mid-phase: sender holds until the checker has caught up
                if (ph == 1 && !paused && n_req - mark_req > PHASE_ITEMS / 2) begin
                    src_rest();
                    while (verdict_q.size() != 0) @(posedge i_clk);
                    paused = 1'b1;
                end
            end
        end

        src_rest();
        wait_drained();

        $display("ran %0d requests over a hand-made table, a saturating frame and 4 phases",
                 n_req);
        $display("verdicts: %0d ok, %0d length, %0d address, %0d crc",
                 n_code[ERR_OK], n_code[ERR_LEN], n_code[ERR_ADDR], n_code[ERR_CRC]);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== modbus_reply_frame_checker_unit.f =====
sv/mrfc_pkg.sv
sv/mrfc_in_if.sv
sv/mrfc_out_if.sv
sv/mrfc_byte_step.sv
sv/modbus_reply_frame_checker_unit.sv
tb/tb_modbus_reply_frame_checker_unit.sv
